[rtl/afs_pkg.sv]
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types and constants of the audio frame sequencer.
// ----------------------------------------------------------------------------
package afs_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  // step numbers at which the sequence acts
  localparam logic [15:0] STEP_Q1   = 16'd7457;
  localparam logic [15:0] STEP_Q2   = 16'd14913;
  localparam logic [15:0] STEP_Q3   = 16'd22371;
  localparam logic [15:0] STEP_IRQ  = 16'd29828;
  localparam logic [15:0] STEP_END4 = 16'd29829;
  localparam logic [15:0] STEP_END5 = 16'd37281;

  // frame control byte layout
  localparam int unsigned     CTRL_MODE_BIT    = 7;
  localparam logic [7:0]      CTRL_INHIBIT_MSK = 8'h40;

  // counter reset delay after a write, by parity
  localparam logic [2:0] DELAY_ODD  = 3'd4;
  localparam logic [2:0] DELAY_EVEN = 3'd5;

  // one input item
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
  } item_t;

  // one result item
  typedef struct packed {
    logic quarter_frame;
    logic half_frame;
    logic irq_read;
    logic irq_pending;
  } result_t;

  // sequencer state
  typedef struct packed {
    logic [15:0] step_count;
    logic        odd_phase;
    logic        reset_pending;
    logic [2:0]  reset_countdown;
    logic        five_step_mode;
    logic        irq_inhibit;
    logic        frame_irq;
  } state_t;

endpackage

[rtl/afs_if.sv]
// ----------------------------------------------------------------------------
// afs channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface afs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data;

  modport source (output valid, output func, output data, input ready);
  modport sink   (input valid, input func, input data, output ready);
endinterface

interface afs_out_if;
  logic valid;
  logic ready;
  logic quarter_frame;
  logic half_frame;
  logic irq_read;
  logic irq_pending;

  modport source (output valid, output quarter_frame, output half_frame,
                  output irq_read, output irq_pending, input ready);
  modport sink   (input valid, input quarter_frame, input half_frame,
                  input irq_read, input irq_pending, output ready);
endinterface

[rtl/afs_in_reg.sv]
// ----------------------------------------------------------------------------
// afs_in_reg
// Input register: holds one accepted item until the step logic takes it.
// ----------------------------------------------------------------------------
module afs_in_reg
  import afs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // free when empty or emptied this cycle
  assign ready_o = !valid_q || ready_i;

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/afs_step_logic.sv]
// ----------------------------------------------------------------------------
// afs_step_logic
// Next state and result of the frame sequencer for one item.
// ----------------------------------------------------------------------------
module afs_step_logic
  import afs_pkg::*;
(
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  always_comb begin
    state_t      s;
    logic [15:0] base;
    logic        qf;
    logic        hf;
    logic        rd;

    s    = state_i;
    base = state_i.step_count;
    qf   = 1'b0;
    hf   = 1'b0;
    rd   = 1'b0;

    case (item_i.func)
      FUNC_TICK: begin
        // pending counter reset counts down first
        if (s.reset_pending) begin
          if (s.reset_countdown != 3'd0) begin
            s.reset_countdown = s.reset_countdown - 3'd1;
          end
          if (s.reset_countdown == 3'd0) begin
            base            = 16'd0;
            s.reset_pending = 1'b0;
          end
        end
        s.odd_phase  = !s.odd_phase;
        s.step_count = base + 16'd1;
        // act on the new step number
        if (s.step_count == STEP_Q1 || s.step_count == STEP_Q3) begin
          qf = 1'b1;
        end else if (s.step_count == STEP_Q2) begin
          qf = 1'b1;
          hf = 1'b1;
        end else if (s.step_count == STEP_IRQ) begin
          if (!s.five_step_mode && !s.irq_inhibit) begin
            s.frame_irq = 1'b1;
          end
        end else if (s.step_count == STEP_END4) begin
          if (!s.five_step_mode) begin
            qf           = 1'b1;
            hf           = 1'b1;
            s.step_count = 16'd0;
          end
        end else if (s.step_count == STEP_END5) begin
          qf           = 1'b1;
          hf           = 1'b1;
          s.step_count = 16'd0;
        end
      end
      FUNC_WRITE: begin
        s.five_step_mode = item_i.data[CTRL_MODE_BIT];
        s.irq_inhibit    = |(item_i.data & CTRL_INHIBIT_MSK);
        if (s.irq_inhibit) begin
          s.frame_irq = 1'b0;
        end
        s.reset_countdown = s.odd_phase ? DELAY_ODD : DELAY_EVEN;
        s.reset_pending   = 1'b1;
        // five-step mode clocks both frames at once
        if (s.five_step_mode) begin
          qf = 1'b1;
          hf = 1'b1;
        end
      end
      FUNC_READ: begin
        rd          = s.frame_irq;
        s.frame_irq = 1'b0;
      end
      default: begin
      end
    endcase

    state_o                = s;
    result_o.quarter_frame = qf;
    result_o.half_frame    = hf;
    result_o.irq_read      = rd;
    result_o.irq_pending   = s.frame_irq;
  end

endmodule

[rtl/apu_frame_sequencer.sv]
// ----------------------------------------------------------------------------
// apu_frame_sequencer
// Audio frame sequencer: ticks, frame-control writes and status reads
// drive a step counter that pulses quarter- and half-frame clocks and
// raises the frame interrupt.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+----------
//  in_i    | in  | func[1:0], data[7:0]                             | valid/ready
//  out_o   | out | quarter_frame, half_frame, irq_read, irq_pending | valid/ready
//
// One item per cycle sustained while out_o.ready is high; an item passes from
// in_i to out_o through the input register, then the result register.
// The sequencer state is updated as an item leaves the input register, so
// each item sees the state left by the one before it.
// A stall on out_o holds both registers; in_i.ready falls only when both
// are full and out_o.ready is low.
// rst_ni clears all state and both valid flags at once.
// ----------------------------------------------------------------------------
module apu_frame_sequencer
  import afs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  afs_in_if.sink          in_i,
  afs_out_if.source       out_o
);

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    stage_ready;
  state_t  state_q;
  state_t  state_d;
  result_t step_res;
  result_t res_q;
  logic    res_valid_q;
  logic    advance;

  assign in_item.func = in_i.func;
  assign in_item.data = in_i.data;

  // input register
  afs_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .ready_i (stage_ready),
    .item_o  (stage_item)
  );

  // sequencer step
  afs_step_logic u_step (
    .state_i  (state_q),
    .item_i   (stage_item),
    .state_o  (state_d),
    .result_o (step_res)
  );

  assign stage_ready = !res_valid_q || out_o.ready;
  assign advance     = stage_valid && stage_ready;

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (stage_ready) begin
      res_valid_q <= stage_valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.quarter_frame = res_q.quarter_frame;
  assign out_o.half_frame    = res_q.half_frame;
  assign out_o.irq_read      = res_q.irq_read;
  assign out_o.irq_pending   = res_q.irq_pending;

  // a half-frame pulse always comes with a quarter-frame pulse
  a_half_has_quarter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.half_frame |-> res_q.quarter_frame)
    else $error("half_frame without quarter_frame");

  // a status read leaves the flag clear
  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.irq_read |-> !res_q.irq_pending)
    else $error("irq flag still set after status read");

  // a pending reset always has ticks left to run
  a_pending_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.reset_pending |-> (state_q.reset_countdown != 3'd0 &&
                               state_q.reset_countdown <= DELAY_EVEN))
    else $error("reset countdown out of range");

  // the step counter stays inside the five-step sequence
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.step_count < STEP_END5)
    else $error("step counter beyond sequence end");

  // the sequencer state moves only when an item advances
  a_result_follows_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an item");

endmodule
